### rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg: shared constants and types for the sorted double-ended queue
// Sizes, command and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE_MIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_MAX = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic  insert;
    logic  rm_min;
    logic  rm_max;
    data_t ins_value;
  } cell_ctl_t;

endpackage

### rtl/sorted_double_ended_queue.sv
// ----------------------------------------------------------------------------
// sorted_double_ended_queue: sorted store with removal at either end
// Keeps signed values in ascending order in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with command and value. A request
//   is taken at a clock edge where in_valid is high and in_stall is low.
//   command selects insert, remove smallest or remove largest.
//   Response channel: out_valid / out_stall with status, removed_value and
//   count. Each request gives exactly one response, in order.
//   The response is presented in the cycle after the request is taken.
//   Throughput: one request per cycle while no response is stalled; every
//   cell of the chain compares and shifts in the same cycle, so the time a
//   command takes does not depend on how many values are held.
//   Stall: the response register holds while out_stall is high; in_stall
//   rises while a response waits and is stalled, and falls as soon as the
//   response can move on, so a new request enters in the cycle it leaves.
//   Reset: rst (synchronous, active high) empties the store and clears
//   out_valid only. No clearing pass is needed; cells start invalid.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sdq_pkg::CMD_W-1:0]  command,
  input  logic signed [sdq_pkg::DATA_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sdq_pkg::ST_W-1:0]   status,
  output logic signed [sdq_pkg::DATA_W-1:0] removed_value,
  output logic [sdq_pkg::CNT_W-1:0]  count
);
  import sdq_pkg::*;

  // Chain state seen at the cell outputs.
  data_t cell_value [DEPTH];
  logic  cell_valid [DEPTH];
  logic  cell_gt    [DEPTH];
  logic  cell_tail  [DEPTH];

  // Neighbor wiring, with the chain ends tied off.
  data_t lft_value  [DEPTH];
  logic  lft_gt     [DEPTH];
  logic  lft_valid  [DEPTH];
  data_t rgt_value  [DEPTH];
  logic  rgt_valid  [DEPTH];

  cell_ctl_t        ctl;
  logic             accept;
  logic             full;
  logic             empty;
  data_t            max_value;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [ST_W-1:0]  status_next;
  data_t            removed_next;

  // Hold the request side only while a finished response is stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (cnt == DEPTH_CNT);
  assign empty = !cell_valid[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        lft_value[i] = '0;
        lft_gt[i]    = 1'b0;
        lft_valid[i] = 1'b1;
      end else begin
        lft_value[i] = cell_value[i-1];
        lft_gt[i]    = cell_gt[i-1];
        lft_valid[i] = cell_valid[i-1];
      end
      if (i == DEPTH-1) begin
        rgt_value[i] = '0;
        rgt_valid[i] = 1'b0;
      end else begin
        rgt_value[i] = cell_value[i+1];
        rgt_valid[i] = cell_valid[i+1];
      end
    end
  end

  // Largest value: exactly one cell flags itself as the tail when not empty.
  always_comb begin
    max_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_tail[i]) begin
        max_value = max_value | cell_value[i];
      end
    end
  end

  // Decode the request into the broadcast cell operation and the response.
  always_comb begin
    ctl.insert    = 1'b0;
    ctl.rm_min    = 1'b0;
    ctl.rm_max    = 1'b0;
    ctl.ins_value = value;
    cnt_next      = cnt;
    status_next   = ST_DONE;
    removed_next  = '0;
    unique case (command)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.insert = accept;
          cnt_next   = cnt + CNT_W'(1);
        end
      end
      CMD_REMOVE_MIN: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.rm_min   = accept;
          cnt_next     = cnt - CNT_W'(1);
          removed_next = cell_value[0];
        end
      end
      CMD_REMOVE_MAX: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.rm_max   = accept;
          cnt_next     = cnt - CNT_W'(1);
          removed_next = max_value;
        end
      end
      default: begin
        // Unused code: leave the store untouched and report done.
        cnt_next = cnt;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_value  (lft_value[g]),
      .left_gt     (lft_gt[g]),
      .left_valid  (lft_valid[g]),
      .right_value (rgt_value[g]),
      .right_valid (rgt_valid[g]),
      .value       (cell_value[g]),
      .valid       (cell_valid[g]),
      .gt          (cell_gt[g]),
      .tail        (cell_tail[g])
    );
  end

  // Occupancy counter: update on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // Response register: load on accept, drop once taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      count         <= cnt_next;
    end
  end

endmodule

### rtl/sdq_cell.sv
// ----------------------------------------------------------------------------
// sdq_cell: one slot of the sorted chain
// Holds one value and its valid bit, compares against the broadcast insert
// value and trades data with its left and right neighbors.
// ----------------------------------------------------------------------------
module sdq_cell (
  input  logic              clk,
  input  logic              rst,
  input  sdq_pkg::cell_ctl_t ctl,
  input  sdq_pkg::data_t    left_value,
  input  logic              left_gt,
  input  logic              left_valid,
  input  sdq_pkg::data_t    right_value,
  input  logic              right_valid,
  output sdq_pkg::data_t    value,
  output logic              valid,
  output logic              gt,
  output logic              tail
);
  import sdq_pkg::*;

  data_t value_next;
  logic  valid_next;

  // Slot holds a value strictly larger than the one being inserted.
  assign gt   = valid && (value > ctl.ins_value);
  assign tail = valid && !right_valid;

  always_comb begin
    value_next = value;
    valid_next = valid;
    priority if (ctl.insert) begin
      // Take the neighbor's value when it also moves up, else drop the new one in.
      if (gt || !valid) begin
        value_next = left_gt ? left_value : ctl.ins_value;
      end
      valid_next = valid || left_valid;
    end else if (ctl.rm_min) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctl.rm_max) begin
      valid_next = valid && right_valid;
    end else begin
      // No operation this cycle: hold the slot.
      value_next = value;
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

### rtl/sdq_checker.sv
// ----------------------------------------------------------------------------
// sdq_checker: port-level assertions for the sorted double-ended queue
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module sdq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sdq_pkg::ST_W-1:0]   status,
  input logic signed [sdq_pkg::DATA_W-1:0] removed_value,
  input logic [sdq_pkg::CNT_W-1:0]  count
);
  import sdq_pkg::*;

  // A stalled response keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
      && $stable(removed_value))
    else $error("stalled response changed");

  // Every taken request shows a response on the next cycle.
  a_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("request without response");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == DEPTH_CNT && removed_value == '0)
    else $error("full status with wrong count");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0 && removed_value == '0)
    else $error("empty status with wrong count");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= DEPTH_CNT && status != 2'd3)
    else $error("count or status out of range");

endmodule

bind sorted_double_ended_queue sdq_checker u_sdq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .removed_value (removed_value),
  .count         (count)
);
